// ===== sv/tnsi_pkg.sv =====
// Shared types and codes for the top-N sorted insert table.
package tnsi_pkg;

  localparam int IdW    = 32;
  localparam int ScoreW = 32;
  localparam int LevelW = 16;
  localparam int SlotW  = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_LOW   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
    logic [LevelW-1:0] level;
  } entry_t;

  typedef struct packed {
    logic dup;
    logic lower;
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_READ,
    S_READ_WAIT,
    S_LOAD,
    S_DONE
  } state_t;

endpackage

// ===== sv/tnsi_if.sv =====
// Valid/ready channel interfaces for the table's command and result items.
interface tnsi_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [tnsi_pkg::IdW-1:0]    entry_id;
  logic [tnsi_pkg::ScoreW-1:0] entry_score;
  logic [tnsi_pkg::LevelW-1:0] entry_level;
  logic [tnsi_pkg::SlotW-1:0]  slot_index;

  modport source (output valid, opcode, entry_id, entry_score, entry_level, slot_index,
                  input ready);
  modport sink (input valid, opcode, entry_id, entry_score, entry_level, slot_index,
                output ready);
endinterface

interface tnsi_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [tnsi_pkg::IdW-1:0]    read_id;
  logic [tnsi_pkg::ScoreW-1:0] read_score;
  logic [tnsi_pkg::LevelW-1:0] read_level;

  modport source (output valid, status, read_id, read_score, read_level, input ready);
  modport sink (input valid, status, read_id, read_score, read_level, output ready);
endinterface

// ===== sv/tnsi_table_mem.sv =====
// Entry memory with one read and one write port; unwritten entries read as zero.
module tnsi_table_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output tnsi_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tnsi_pkg::entry_t wr_data
);
  import tnsi_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  entry_t           rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== sv/tnsi_cmp_unit.sv =====
// Shared compare unit: stored entry against the new entry.
module tnsi_cmp_unit (
  input  tnsi_pkg::entry_t   stored,
  input  tnsi_pkg::entry_t   cand,
  output tnsi_pkg::cmp_res_t res
);
  import tnsi_pkg::*;

  always_comb begin
    res.dup   = (stored.id == cand.id) && (stored.score == cand.score) &&
                (stored.level == cand.level);
    res.lower = stored.score < cand.score;
  end

endmodule

// ===== sv/top_n_sorted_insert_table_unit.sv =====
// Top level of the top-N sorted insert table: sequencer, memory and compare unit.
// Usage:
//   in_ch carries one command item (insert, read or load) per valid/ready handshake;
//   out_ch returns exactly one result item (status and read fields) per command.
//   The table holds TABLE_DEPTH entries, zero after reset; inserts keep descending score order, loads write as given.
// Insert: every entry is scanned through the single memory read port and compare
//   unit, then each entry moved down by the insert takes one read and one write.
//   One command is worked on at a time; in_ch.ready is high only when idle.
// Reset: synchronous, active low; the table reads as all zero afterwards and no
//   result is pending.
// Stall: a result waits in the output register while out_ch.ready is low; the next
//   command is accepted meanwhile and holds its own result until the register frees.
module top_n_sorted_insert_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  tnsi_in_if.sink    in_ch,
  tnsi_out_if.source out_ch
);
  import tnsi_pkg::*;

  localparam int            AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST    = AW'(TABLE_DEPTH - 1);
  localparam logic [SlotW:0] DEPTH_W = (SlotW + 1)'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [1:0]       op_r;
  entry_t           ent_r;
  logic [SlotW-1:0] idx_r;
  logic [AW-1:0]    scan_r;
  logic             iss_done_r;
  logic             pend_r;
  logic [AW-1:0]    pend_idx_r;
  logic             dup_r;
  logic             found_r;
  logic             low_r;
  logic [AW-1:0]    pos_r;
  logic [AW-1:0]    sh_r;
  logic [AW-1:0]    sh_dec;
  logic [1:0]       res_status_r;
  entry_t           res_entry_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  entry_t           out_entry_r;

  logic             in_range;
  logic             out_free;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  cmp_res_t         cmp;

  assign in_range = {1'b0, idx_r} < DEPTH_W;
  assign sh_dec   = sh_r - AW'(1);
  assign out_free = !out_valid_r || out_ch.ready;

  tnsi_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tnsi_cmp_unit u_cmp (
    .stored (rd_data),
    .cand   (ent_r),
    .res    (cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op_r)
          OP_INSERT: state_nxt = S_SCAN;
          OP_READ:   state_nxt = in_range ? S_READ : S_DONE;
          OP_LOAD:   state_nxt = in_range ? S_LOAD : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (pend_r && (pend_idx_r == LAST)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (dup_r || low_r) state_nxt = S_DONE;
        else if (pos_r == LAST) state_nxt = S_PLACE;
        else state_nxt = S_SHIFT_RD;
      end
      S_SHIFT_RD:  state_nxt = S_SHIFT_WR;
      S_SHIFT_WR:  state_nxt = (sh_dec == pos_r) ? S_PLACE : S_SHIFT_RD;
      S_PLACE:     state_nxt = S_DONE;
      S_READ:      state_nxt = S_READ_WAIT;
      S_READ_WAIT: state_nxt = S_DONE;
      S_LOAD:      state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = ent_r;
    case (state_r)
      S_SCAN: begin
        rd_en   = !iss_done_r;
        rd_addr = scan_r;
      end
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = sh_dec;
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh_r;
        wr_data = rd_data;
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[AW-1:0];
      end
      S_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r        <= in_ch.opcode;
            ent_r.id    <= in_ch.entry_id;
            ent_r.score <= in_ch.entry_score;
            ent_r.level <= in_ch.entry_level;
            idx_r       <= in_ch.slot_index;
          end
        end
        S_DISPATCH: begin
          scan_r       <= '0;
          iss_done_r   <= 1'b0;
          pend_r       <= 1'b0;
          dup_r        <= 1'b0;
          found_r      <= 1'b0;
          low_r        <= 1'b0;
          pos_r        <= LAST;
          res_status_r <= ST_RANGE;
          res_entry_r  <= '0;
        end
        S_SCAN: begin
          // Issue one read a cycle; compare the entry read the cycle before.
          if (!iss_done_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= scan_r;
            if (scan_r == LAST) iss_done_r <= 1'b1;
            else scan_r <= scan_r + AW'(1);
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            dup_r <= dup_r | cmp.dup;
            if (cmp.lower && !found_r) begin
              found_r <= 1'b1;
              pos_r   <= pend_idx_r;
            end
            if (pend_idx_r == LAST) low_r <= !cmp.lower;
          end
        end
        S_DECIDE: begin
          sh_r <= LAST;
          if (dup_r) res_status_r <= ST_DUP;
          else if (low_r) res_status_r <= ST_LOW;
        end
        S_SHIFT_WR: begin
          sh_r <= sh_dec;
        end
        S_PLACE: begin
          res_status_r <= ST_DONE;
        end
        S_READ_WAIT: begin
          res_entry_r  <= rd_data;
          res_status_r <= ST_DONE;
        end
        S_LOAD: begin
          res_status_r <= ST_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_entry_r  <= res_entry_r;
          end
        end
        default: begin
          pend_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_id    = out_entry_r.id;
  assign out_ch.read_score = out_entry_r.score;
  assign out_ch.read_level = out_entry_r.level;

endmodule

// ===== tb/tb_top_n_sorted_insert_table_unit.sv =====
// Self-checking testbench for the top-N sorted insert table: predicted results, random traffic.
`timescale 1ns / 100ps

module tb;
  import tnsi_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    entry_t           ent;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
    logic [LevelW-1:0] level;
  } result_t;

  class table_scoreboard;
    entry_t  slots[TABLE_DEPTH];
    result_t expected_q[$];
    int      errors;

    function void clear_table();
      foreach (slots[i]) slots[i] = '0;
      expected_q.delete();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command to the table copy and queue its result.
    function void note_command(cmd_t c);
      result_t r;
      int      pos;
      bit      dup;
      r = '0;
      r.status = ST_RANGE;
      case (c.op)
        OP_INSERT: begin
          dup = 1'b0;
          foreach (slots[i]) if (slots[i] == c.ent) dup = 1'b1;
          if (dup) begin
            r.status = ST_DUP;
          end else if (c.ent.score <= slots[TABLE_DEPTH-1].score) begin
            r.status = ST_LOW;
          end else begin
            pos = TABLE_DEPTH - 1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
              if (slots[i].score < c.ent.score) pos = i;
            for (int i = TABLE_DEPTH - 1; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = c.ent;
            r.status = ST_DONE;
          end
        end
        OP_READ: begin
          if (c.slot < TABLE_DEPTH) begin
            r.status = ST_DONE;
            r.id     = slots[c.slot].id;
            r.score  = slots[c.slot].score;
            r.level  = slots[c.slot].level;
          end
        end
        OP_LOAD: begin
          if (c.slot < TABLE_DEPTH) begin
            slots[c.slot] = c.ent;
            r.status = ST_DONE;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void field_mismatch(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        field_mismatch("status", 32'(want.status), 32'(got.status));
      if (got.id !== want.id) field_mismatch("read_id", want.id, got.id);
      if (got.score !== want.score) field_mismatch("read_score", want.score, got.score);
      if (got.level !== want.level)
        field_mismatch("read_level", 32'(want.level), 32'(got.level));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  bit   hold_req;
  int   cycle_count;

  table_scoreboard sb;

  tnsi_in_if  in_ch ();
  tnsi_out_if out_ch ();

  top_n_sorted_insert_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic cmd_t make_cmd(logic [1:0] op, logic [31:0] id, logic [31:0] score,
                                    logic [15:0] level, logic [5:0] slot);
    cmd_t c;
    c.op        = op;
    c.ent.id    = id;
    c.ent.score = score;
    c.ent.level = level;
    c.slot      = slot;
    return c;
  endfunction

  // Mostly inserts near the scores already held, so ties and shifts happen often.
  function automatic cmd_t rand_command();
    cmd_t        c;
    int          k;
    int          j;
    logic [31:0] lo;
    logic [31:0] hi;
    k = $urandom_range(0, 99);
    c = make_cmd(OP_INSERT, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                 SlotW'($urandom_range(0, TABLE_DEPTH - 1)));
    if ($urandom_range(0, 3) == 0) c.ent.level = 16'($urandom_range(0, 3));
    if (k < 55) begin
      j = $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 9))
        0, 1: ;
        2, 3, 4, 5: c.ent.score = sb.slots[j].score + $urandom_range(0, 2) - 1;
        6: c.ent.score = $urandom_range(0, 255);
        7: c.ent.score = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: c.ent = sb.slots[j];
      endcase
    end else if (k < 80) begin
      c.op = OP_READ;
      if ($urandom_range(0, 7) == 0) c.slot = SlotW'($urandom_range(0, 63));
    end else if (k < 92) begin
      c.op = OP_LOAD;
      // keep the table sorted on most loads
      if ($urandom_range(0, 9) < 7) begin
        lo = (c.slot == TABLE_DEPTH - 1) ? 32'd0 : sb.slots[c.slot + 1].score;
        hi = (c.slot == 0) ? 32'hFFFF_FFFF : sb.slots[c.slot - 1].score;
        if (hi >= lo) c.ent.score = $urandom_range(hi, lo);
      end
    end else if (k < 96) begin
      c.op   = ($urandom_range(0, 1) == 0) ? OP_READ : OP_LOAD;
      c.slot = SlotW'($urandom_range(TABLE_DEPTH, 63));
    end else begin
      c.op   = OP_UNUSED;
      c.slot = SlotW'($urandom_range(0, 63));
    end
    return c;
  endfunction

  task automatic send_command(input cmd_t c);
    if (!steady && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= c.op;
    in_ch.entry_id    <= c.ent.id;
    in_ch.entry_score <= c.ent.score;
    in_ch.entry_level <= c.ent.level;
    in_ch.slot_index  <= c.slot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c);
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Fill every slot with a descending run of modest scores, ties included.
  task automatic refill_table();
    logic [31:0] cur;
    cur = $urandom_range(64, 200000);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_command(make_cmd(OP_LOAD, $urandom, cur, 16'($urandom_range(0, 65535)),
                            SlotW'(i)));
      cur = cur - $urandom_range(0, 3);
    end
  endtask

  initial begin
    sb = new;
    sb.clear_table();
    steady   = 1'b0;
    hold_req = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_INSERT;
    in_ch.entry_id    <= '0;
    in_ch.entry_score <= '0;
    in_ch.entry_level <= '0;
    in_ch.slot_index  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset contents, range errors, duplicates, ties, unsorted table
    send_command(make_cmd(OP_READ, '0, '0, '0, '0));
    send_command(make_cmd(OP_READ, '0, '0, '0, SlotW'(TABLE_DEPTH - 1)));
    send_command(make_cmd(OP_READ, '0, '0, '0, SlotW'(TABLE_DEPTH)));
    send_command(make_cmd(OP_READ, '1, '1, '1, 6'd63));
    send_command(make_cmd(OP_LOAD, '1, '1, '1, 6'd63));
    send_command(make_cmd(OP_UNUSED, '1, '1, '1, 6'd63));
    send_command(make_cmd(OP_INSERT, '0, '0, '0, '0));
    send_command(make_cmd(OP_INSERT, 32'd1, '0, '0, '0));
    send_command(make_cmd(OP_INSERT, '1, '1, '1, '0));
    send_command(make_cmd(OP_INSERT, '1, '1, '1, '0));
    send_command(make_cmd(OP_INSERT, 32'd5, '1, 16'd7, '0));
    send_command(make_cmd(OP_INSERT, 32'd6, 32'd1, 16'd0, '0));
    send_command(make_cmd(OP_INSERT, 32'd7, 32'd1, 16'd1, '0));
    send_command(make_cmd(OP_LOAD, 32'd9, 32'd0, 16'd3, '0));
    send_command(make_cmd(OP_INSERT, 32'd8, 32'd2, 16'd2, '0));
    send_command(make_cmd(OP_LOAD, 32'hFF, 32'd100, 16'd4, SlotW'(TABLE_DEPTH - 1)));
    send_command(make_cmd(OP_INSERT, 32'd10, 32'd100, 16'd5, '0));
    send_command(make_cmd(OP_INSERT, 32'd11, 32'd101, 16'd6, '0));
    send_command(make_cmd(OP_LOAD, '1, '1, '1, '0));
    for (int i = 0; i < 4; i++) send_command(make_cmd(OP_READ, '0, '0, '0, SlotW'(i)));
    send_command(make_cmd(OP_READ, '0, '0, '0, SlotW'(TABLE_DEPTH - 1)));
    wait_results_done();

    // hold the result side off while commands keep coming
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_command(rand_command());
    steady = 1'b0;
    wait_results_done();

    for (int n = 0; n < 1000; n++) begin
      steady = (n >= 400 && n < 600);
      if (n % 150 == 0) refill_table();
      if (n == 700) wait_results_done();
      send_command(rand_command());
    end
    steady = 1'b0;

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS top_n_sorted_insert_table_unit");
    end else begin
      $display("FAIL top_n_sorted_insert_table_unit");
    end
    $finish;
  end

  // Result side: random stalls except while steady, and a long hold-off on request.
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.read_id, out_ch.read_score, out_ch.read_level});
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL top_n_sorted_insert_table_unit");
        $finish;
      end
    end
  end

endmodule
